>>> design/hkrd_pkg.sv
// shared types and constants for the boot-keyboard report differ
// no dependencies; compiled first
`default_nettype none

package hkrd_pkg;

  localparam int CODE_W        = 8;
  localparam int LEN_W         = 7;
  localparam int MOD_BITS      = 8;
  localparam int INPUT_SLOTS   = 6;
  localparam int MIN_REPORT_LEN = 8;

  localparam logic [CODE_W-1:0] MOD_BASE_CODE = 8'hE0;

  // controller to datapath
  typedef struct packed {
    logic capture;   // load the new report
    logic eval;      // build the event flag vector
    logic scan;      // walk the candidates, one per cycle while the output does not stall
    logic commit;    // new report becomes the previous report
  } hkrd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic short_rpt; // incoming report below minimum length
    logic done;      // no events left to emit
  } hkrd_status_t;

endpackage

`default_nettype wire

>>> design/hkrd_if.sv
// report and event channel interfaces (valid/ready)
// depends on hkrd_pkg
`default_nettype none

interface hkrd_in_if import hkrd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [LEN_W-1:0]  report_len;
  logic [CODE_W-1:0] modifier_bits;
  logic [CODE_W-1:0] slot0_code;
  logic [CODE_W-1:0] slot1_code;
  logic [CODE_W-1:0] slot2_code;
  logic [CODE_W-1:0] slot3_code;
  logic [CODE_W-1:0] slot4_code;
  logic [CODE_W-1:0] slot5_code;

  modport source (output valid, report_len, modifier_bits, slot0_code, slot1_code,
                  slot2_code, slot3_code, slot4_code, slot5_code, input ready);
  modport sink (input valid, report_len, modifier_bits, slot0_code, slot1_code,
                slot2_code, slot3_code, slot4_code, slot5_code, output ready);
endinterface

interface hkrd_out_if import hkrd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] usage_code;
  logic              pressed;
  logic              last_event;

  modport source (output valid, usage_code, pressed, last_event, input ready);
  modport sink (input valid, usage_code, pressed, last_event, output ready);
endinterface

`default_nettype wire

>>> design/hkrd_ctrl.sv
// sequencing state machine: accept, evaluate, scan, commit
// depends on hkrd_pkg
`default_nettype none

module hkrd_ctrl import hkrd_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   in_valid,
  output logic        in_ready,
  input  wire hkrd_status_t status,
  output hkrd_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EVAL = 3'b010,
    ST_SCAN = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd.capture = accept && !status.short_rpt;
    cmd.eval    = (state_r == ST_EVAL);
    cmd.scan    = (state_r == ST_SCAN);
    cmd.commit  = (state_r == ST_SCAN) && status.done;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && !status.short_rpt) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (status.done) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/hkrd_datapath.sv
// report registers, event flag compare, candidate walk and output register
// depends on hkrd_pkg; driven by hkrd_ctrl commands
`default_nettype none

module hkrd_datapath import hkrd_pkg::*; #(
  parameter int KEY_SLOTS = 6
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [LEN_W-1:0]  in_report_len,
  input  wire logic [CODE_W-1:0] in_modifier_bits,
  input  wire logic [CODE_W-1:0] in_slot_codes [INPUT_SLOTS],
  input  wire hkrd_cmd_t         cmd,
  output hkrd_status_t           status,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output logic [CODE_W-1:0]      out_usage_code,
  output logic                   out_pressed,
  output logic                   out_last_event
);

  localparam int NCAND = MOD_BITS + 2 * KEY_SLOTS;
  localparam int IW    = $clog2(NCAND);
  localparam int SW    = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

  logic [CODE_W-1:0] cur_mods_r, prior_mods_r;
  logic [CODE_W-1:0] cur_slots_r   [KEY_SLOTS];
  logic [CODE_W-1:0] prior_slots_r [KEY_SLOTS];
  logic [NCAND-1:0]  rem_r;
  logic [IW-1:0]     idx_r;
  logic              out_valid_r;
  logic [CODE_W-1:0] code_r;
  logic              pressed_r;
  logic              last_r;

  logic [NCAND-1:0]  flags;
  logic [KEY_SLOTS-1:0] rel_hit, prs_hit;
  logic [IW-1:0]     rel_pos, prs_pos;
  logic [CODE_W-1:0] cand_code;
  logic              cand_pressed;
  logic              cur_bit, out_free, load_out, step;
  logic [NCAND-1:0]  rem_clr;
  logic              last_nxt;

  // new report capture; slots past the input fields read as empty
  always_ff @(posedge clk) begin
    if (cmd.capture) cur_mods_r <= in_modifier_bits;
  end

  for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_cap
    if (g < INPUT_SLOTS) begin : g_in
      always_ff @(posedge clk) begin
        if (cmd.capture) cur_slots_r[g] <= in_slot_codes[g];
      end
    end else begin : g_zero
      always_ff @(posedge clk) begin
        if (cmd.capture) cur_slots_r[g] <= '0;
      end
    end
  end

  // previous report, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prior_mods_r <= '0;
      for (int i = 0; i < KEY_SLOTS; i++) prior_slots_r[i] <= '0;
    end else if (cmd.commit) begin
      prior_mods_r <= cur_mods_r;
      for (int i = 0; i < KEY_SLOTS; i++) prior_slots_r[i] <= cur_slots_r[i];
    end
  end

  // membership compare: modifier changes, releases, presses
  always_comb begin
    for (int j = 0; j < KEY_SLOTS; j++) begin
      rel_hit[j] = 1'b0;
      prs_hit[j] = 1'b0;
      for (int k = 0; k < KEY_SLOTS; k++) begin
        if (cur_slots_r[k] == prior_slots_r[j]) rel_hit[j] = 1'b1;
        if (prior_slots_r[k] == cur_slots_r[j]) prs_hit[j] = 1'b1;
      end
    end
    flags[MOD_BITS-1:0] = cur_mods_r ^ prior_mods_r;
    for (int j = 0; j < KEY_SLOTS; j++) begin
      flags[MOD_BITS + j] = (prior_slots_r[j] != '0) && !rel_hit[j];
      flags[MOD_BITS + KEY_SLOTS + j] = (cur_slots_r[j] != '0) && !prs_hit[j];
    end
  end

  // candidate at the walk position
  assign rel_pos = idx_r - IW'(MOD_BITS);
  assign prs_pos = idx_r - IW'(MOD_BITS + KEY_SLOTS);

  always_comb begin
    if (idx_r < IW'(MOD_BITS)) begin
      cand_code    = MOD_BASE_CODE + {5'b0, idx_r[2:0]};
      cand_pressed = cur_mods_r[idx_r[2:0]];
    end else if (idx_r < IW'(MOD_BITS + KEY_SLOTS)) begin
      cand_code    = prior_slots_r[rel_pos[SW-1:0]];
      cand_pressed = 1'b0;
    end else begin
      cand_code    = cur_slots_r[prs_pos[SW-1:0]];
      cand_pressed = 1'b1;
    end
  end

  assign cur_bit  = rem_r[idx_r];
  assign out_free = !out_valid_r || out_ready;
  assign load_out = cmd.scan && cur_bit && out_free;
  assign step     = cmd.scan && (!cur_bit || out_free) && (idx_r != IW'(NCAND - 1));
  assign rem_clr  = rem_r & ~(NCAND'(1) << idx_r);
  assign last_nxt = (rem_clr == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
      idx_r <= '0;
    end else if (cmd.eval) begin
      rem_r <= flags;
      idx_r <= '0;
    end else begin
      if (load_out) rem_r <= rem_clr;
      if (step) idx_r <= idx_r + IW'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      code_r    <= cand_code;
      pressed_r <= cand_pressed;
      last_r    <= last_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_usage_code = code_r;
  assign out_pressed    = pressed_r;
  assign out_last_event = last_r;

  always_comb begin
    status.short_rpt = in_report_len < LEN_W'(MIN_REPORT_LEN);
    status.done      = (rem_r == '0);
  end

  // the final event leaves nothing pending
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    load_out && last_nxt |=> rem_r == '0)
    else $error("pending events remain after final event");

  // evaluation loads the flags of the held reports
  a_eval_flags: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.eval |=> rem_r == $past(flags) && idx_r == '0)
    else $error("flag vector not loaded on evaluation");

  // commit takes the held report as the previous one
  a_commit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> prior_mods_r == $past(cur_mods_r))
    else $error("previous modifiers not updated on commit");

  // no emission once the walk reports done
  a_no_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
    status.done |-> !load_out)
    else $error("event emitted with nothing pending");

endmodule

`default_nettype wire

>>> design/hid_keyboard_report_diff_unit.sv
// boot-keyboard report differ, top level
// depends on hkrd_pkg, hkrd_if, hkrd_ctrl, hkrd_datapath
//
// usage:
//   in_if carries one boot-keyboard report per item: length, modifier byte
//   and six key slots. out_if carries key events: usage code, pressed flag
//   and a last_event mark on the final event of a report.
//   events come in three groups: changed modifiers (0xE0 + bit) in bit
//   order, then releases in previous-slot order, then presses in new-slot
//   order. a report shorter than 8 bytes is taken and dropped.
// timing:
//   a valid report is first held in the evaluate state for the flag compare,
//   then the walk looks at one of the 8 + 2*KEY_SLOTS candidates per cycle
//   while out_if does not stall, and it ends with the commit in the scan
//   state once no events are pending. in_if.ready is high only between items.
//   the output register lets the next report be taken while the final event
//   still waits; a stall on out_if holds the walk at the pending event.
// reset:
//   synchronous active-low; previous report cleared to all zero, no events
//   pending
`default_nettype none

module hid_keyboard_report_diff_unit import hkrd_pkg::*; #(
  parameter int KEY_SLOTS = 6
) (
  input  wire logic clk,
  input  wire logic rst_n,
  hkrd_in_if.sink   in_if,
  hkrd_out_if.source out_if
);

  hkrd_cmd_t         cmd;
  hkrd_status_t      status;
  logic [CODE_W-1:0] slot_codes [INPUT_SLOTS];

  // slot fields gathered into an array for the datapath
  assign slot_codes[0] = in_if.slot0_code;
  assign slot_codes[1] = in_if.slot1_code;
  assign slot_codes[2] = in_if.slot2_code;
  assign slot_codes[3] = in_if.slot3_code;
  assign slot_codes[4] = in_if.slot4_code;
  assign slot_codes[5] = in_if.slot5_code;

  hkrd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .status   (status),
    .cmd      (cmd)
  );

  hkrd_datapath #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_report_len    (in_if.report_len),
    .in_modifier_bits (in_if.modifier_bits),
    .in_slot_codes    (slot_codes),
    .cmd              (cmd),
    .status           (status),
    .out_ready        (out_if.ready),
    .out_valid        (out_if.valid),
    .out_usage_code   (out_if.usage_code),
    .out_pressed      (out_if.pressed),
    .out_last_event   (out_if.last_event)
  );

endmodule

`default_nettype wire

>>> tb/tb_hid_keyboard_report_diff_unit.sv
`timescale 1ns / 1ps
// self-checking bench for the boot-keyboard report differ: directed table, then random reports
// depends on hkrd_pkg, hkrd_if and the hid_keyboard_report_diff_unit RTL

module tb_hid_keyboard_report_diff_unit;
  import hkrd_pkg::*;

  // one report as it goes onto the input channel
  typedef logic [0:INPUT_SLOTS-1][CODE_W-1:0] slot_row_t;

  typedef struct packed {
    logic [LEN_W-1:0]    len;
    logic [MOD_BITS-1:0] mods;
    slot_row_t           slot;
  } report_t;

  // one key event as it leaves the result channel
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              pressed;
    logic              last;
  } key_event_t;

  // how a table row gets its expected events
  typedef enum logic [1:0] {
    BY_PREDICTOR,
    NO_EVENTS,
    ONE_EVENT
  } outcome_t;

  typedef struct packed {
    report_t           rpt;
    outcome_t          outcome;
    logic [CODE_W-1:0] code;
    logic              pressed;
  } plan_row_t;

  localparam int PLAN_ROWS = 22;
  localparam int RANDOM_PER_PHASE = 70;
  localparam int TAIL_CYCLES = 40;

  // directed table, walked in order straight after reset
  localparam plan_row_t DIRECTED_PLAN [PLAN_ROWS] = '{
    // same as the cleared state: nothing changes
    '{'{7'd8,   8'h00, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}}, NO_EVENTS, 8'h00, 1'b0},
    // short reports, all bits set or length zero: dropped
    '{'{7'd7,   8'hFF, '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}}, NO_EVENTS, 8'h00, 1'b0},
    '{'{7'd0,   8'h00, '{8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06}}, NO_EVENTS, 8'h00, 1'b0},
    // single key down, single modifier down, then up
    '{'{7'd8,   8'h00, '{8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}}, ONE_EVENT, 8'h04, 1'b1},
    '{'{7'd8,   8'h01, '{8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}}, ONE_EVENT, 8'hE0, 1'b1},
    '{'{7'd8,   8'h00, '{8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}}, ONE_EVENT, 8'hE0, 1'b0},
    // all modifiers and all slots at the top codes
    '{'{7'd64,  8'hFF, '{8'hFF, 8'hFE, 8'hFD, 8'hFC, 8'hFB, 8'hFA}}, BY_PREDICTOR, 8'h00, 1'b0},
    // full turnover: every modifier and every slot changes, longest burst
    '{'{7'd127, 8'h00, '{8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06}}, BY_PREDICTOR, 8'h00, 1'b0},
    '{'{7'd127, 8'h00, '{8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06}}, NO_EVENTS, 8'h00, 1'b0},
    // short report with new content must not disturb the stored one
    '{'{7'd7,   8'h5A, '{8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80}}, NO_EVENTS, 8'h00, 1'b0},
    '{'{7'd8,   8'h00, '{8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06}}, NO_EVENTS, 8'h00, 1'b0},
    // same code in several slots, pressed then released
    '{'{7'd8,   8'h00, '{8'h09, 8'h09, 8'h09, 8'h01, 8'h00, 8'h00}}, BY_PREDICTOR, 8'h00, 1'b0},
    '{'{7'd8,   8'h00, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}}, BY_PREDICTOR, 8'h00, 1'b0},
    // keys moving between slots are not events
    '{'{7'd8,   8'h00, '{8'h10, 8'h11, 8'h12, 8'h00, 8'h00, 8'h00}}, BY_PREDICTOR, 8'h00, 1'b0},
    '{'{7'd8,   8'h00, '{8'h00, 8'h12, 8'h00, 8'h10, 8'h00, 8'h11}}, NO_EVENTS, 8'h00, 1'b0},
    // modifier patterns only
    '{'{7'd8,   8'hAA, '{8'h00, 8'h12, 8'h00, 8'h10, 8'h00, 8'h11}}, BY_PREDICTOR, 8'h00, 1'b0},
    '{'{7'd8,   8'h55, '{8'h00, 8'h12, 8'h00, 8'h10, 8'h00, 8'h11}}, BY_PREDICTOR, 8'h00, 1'b0},
    '{'{7'd9,   8'h80, '{8'h00, 8'h12, 8'h00, 8'h10, 8'h00, 8'h11}}, BY_PREDICTOR, 8'h00, 1'b0},
    // slot codes that collide with modifier codes, then bottom and top codes repeated
    '{'{7'd8,   8'h80, '{8'hE0, 8'hE7, 8'h00, 8'h00, 8'h00, 8'h00}}, BY_PREDICTOR, 8'h00, 1'b0},
    '{'{7'd8,   8'h80, '{8'hFF, 8'h01, 8'hFF, 8'h01, 8'h00, 8'h00}}, BY_PREDICTOR, 8'h00, 1'b0},
    '{'{7'd1,   8'h00, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}}, NO_EVENTS, 8'h00, 1'b0},
    '{'{7'd8,   8'h00, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}}, BY_PREDICTOR, 8'h00, 1'b0}
  };

  // idle mixes per phase: none, sender mostly idle, receiver mostly stalled, both
  localparam int unsigned SENDER_IDLE [4] = '{0, 85, 0, 21};
  localparam int unsigned RECEIVER_STALL [4] = '{0, 0, 85, 21};

  logic clk = 1'b0;
  logic rst_n;

  hkrd_in_if  in_if ();
  hkrd_out_if out_if ();

  hid_keyboard_report_diff_unit #(
    .KEY_SLOTS(INPUT_SLOTS)
  ) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  // 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor copy of the stored report
  logic [MOD_BITS-1:0] held_mods;
  slot_row_t           held_slots;

  key_event_t pending_events[$];

  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;
  int          mismatches;
  int          events_seen;
  int          reports_taken;
  int          short_reports;

  task automatic report_mismatch(input string what);
    $display("ERROR %0t ns: %s", $time, what);
    mismatches++;
  endtask

  function automatic bit code_held(input slot_row_t slots, input logic [CODE_W-1:0] code);
    for (int i = 0; i < INPUT_SLOTS; i++) begin
      if (slots[i] == code) return 1'b1;
    end
    return 1'b0;
  endfunction

  // works out the events one accepted report causes and takes it as the stored report;
  // queue_events low only moves the state along (rows with typed-in results)
  function automatic void diff_report(input report_t r, input bit queue_events);
    key_event_t          burst[$];
    logic [MOD_BITS-1:0] flipped;
    logic [CODE_W-1:0]   code;
    if (r.len < MIN_REPORT_LEN) return;
    // modifier changes first, in bit order
    flipped = r.mods ^ held_mods;
    for (int i = 0; i < MOD_BITS; i++) begin
      if (flipped[i]) begin
        code = MOD_BASE_CODE + CODE_W'(i);
        burst.push_back('{code, r.mods[i], 1'b0});
      end
    end
    // then releases in old slot order, then presses in new slot order
    for (int i = 0; i < INPUT_SLOTS; i++) begin
      if (held_slots[i] != '0 && !code_held(r.slot, held_slots[i]))
        burst.push_back('{held_slots[i], 1'b0, 1'b0});
    end
    for (int i = 0; i < INPUT_SLOTS; i++) begin
      if (r.slot[i] != '0 && !code_held(held_slots, r.slot[i]))
        burst.push_back('{r.slot[i], 1'b1, 1'b0});
    end
    if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
    held_mods  = r.mods;
    held_slots = r.slot;
    if (queue_events) pending_events = {pending_events, burst};
  endfunction

  task automatic put_on_bus(input report_t r);
    in_if.report_len    = r.len;
    in_if.modifier_bits = r.mods;
    in_if.slot0_code    = r.slot[0];
    in_if.slot1_code    = r.slot[1];
    in_if.slot2_code    = r.slot[2];
    in_if.slot3_code    = r.slot[3];
    in_if.slot4_code    = r.slot[4];
    in_if.slot5_code    = r.slot[5];
  endtask

  // called at a falling edge; returns at the falling edge after the item is taken,
  // with valid still high so a following item can go out back to back
  task automatic send_report(input report_t r, input outcome_t outcome,
                             input logic [CODE_W-1:0] code, input logic pressed);
    report_t noise;
    while ($urandom_range(99) < sender_idle_pct) begin
      // idle cycle: valid low with junk on the payload
      noise = report_t'({$urandom, $urandom});
      in_if.valid = 1'b0;
      put_on_bus(noise);
      @(negedge clk);
    end
    put_on_bus(r);
    in_if.valid = 1'b1;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    // taken on this edge
    reports_taken++;
    if (r.len < MIN_REPORT_LEN) short_reports++;
    diff_report(r, outcome == BY_PREDICTOR);
    if (outcome == ONE_EVENT) pending_events.push_back('{code, pressed, 1'b1});
    @(negedge clk);
  endtask

  // random report drawn from the previous one: mostly small edits of a live keyboard
  // state, now and then an unchanged report or a completely fresh one
  function automatic report_t next_report(input report_t cur);
    report_t r;
    int      k;
    int      b;
    r = cur;
    case ($urandom_range(9))
      0: begin
        r.mods = MOD_BITS'($urandom);
        for (k = 0; k < INPUT_SLOTS; k++)
          r.slot[k] = ($urandom_range(2) == 0) ? '0 : CODE_W'($urandom);
      end
      1: ; // unchanged report
      default: begin
        if ($urandom_range(1) == 1) begin
          b = $urandom_range(MOD_BITS - 1);
          r.mods[b] = ~r.mods[b];
        end
        repeat ($urandom_range(2, 1)) begin
          k = $urandom_range(INPUT_SLOTS - 1);
          case ($urandom_range(3))
            0:       r.slot[k] = '0;
            3:       r.slot[k] = CODE_W'($urandom);
            default: r.slot[k] = CODE_W'($urandom_range(15, 4)); // small pool, many repeats
          endcase
        end
      end
    endcase
    // lengths: mostly the boot size, some short ones, some long ones up to the field max
    case ($urandom_range(9))
      0:       r.len = LEN_W'($urandom_range(MIN_REPORT_LEN - 1));
      1, 2:    r.len = LEN_W'($urandom_range(127, MIN_REPORT_LEN + 1));
      default: r.len = LEN_W'(MIN_REPORT_LEN);
    endcase
    return r;
  endfunction

  // receiver: ready redrawn at every falling edge
  always @(negedge clk) begin
    out_if.ready = ($urandom_range(99) >= receiver_stall_pct);
  end

  // result checker: every taken event against the oldest expectation
  always @(posedge clk) begin
    key_event_t want;
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      events_seen++;
      if (pending_events.size() == 0) begin
        report_mismatch($sformatf("unexpected event code %02h pressed %0b last %0b",
                                  out_if.usage_code, out_if.pressed, out_if.last_event));
      end else begin
        want = pending_events.pop_front();
        if (out_if.usage_code !== want.code)
          report_mismatch($sformatf("usage_code %02h, want %02h", out_if.usage_code, want.code));
        if (out_if.pressed !== want.pressed)
          report_mismatch($sformatf("pressed %0b, want %0b (code %02h)",
                                    out_if.pressed, want.pressed, want.code));
        if (out_if.last_event !== want.last)
          report_mismatch($sformatf("last_event %0b, want %0b (code %02h)",
                                    out_if.last_event, want.last, want.code));
      end
    end
  end

  // run limit, far above the slowest passing run
  initial begin
    #8_000_000;
    $display("ERROR: run limit reached, %0d events still expected", pending_events.size());
    $display("hid_keyboard_report_diff_unit: mismatch");
    $finish;
  end

  initial begin
    report_t cur;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    mismatches    = 0;
    events_seen   = 0;
    reports_taken = 0;
    short_reports = 0;
    held_mods     = '0;
    held_slots    = '0;
    rst_n         = 1'b0;
    in_if.valid   = 1'b0;
    out_if.ready  = 1'b0;
    put_on_bus('0);

    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // directed table, no idling
    for (int i = 0; i < PLAN_ROWS; i++) begin
      send_report(DIRECTED_PLAN[i].rpt, DIRECTED_PLAN[i].outcome,
                  DIRECTED_PLAN[i].code, DIRECTED_PLAN[i].pressed);
    end
    cur = DIRECTED_PLAN[PLAN_ROWS-1].rpt;

    // random reports under each idle mix in turn
    for (int p = 0; p < 4; p++) begin
      sender_idle_pct    = SENDER_IDLE[p];
      receiver_stall_pct = RECEIVER_STALL[p];
      repeat (RANDOM_PER_PHASE) begin
        cur = next_report(cur);
        send_report(cur, BY_PREDICTOR, '0, 1'b0);
      end
    end
    in_if.valid = 1'b0;

    // drain, then watch a while longer for stray events
    receiver_stall_pct = 0;
    while (pending_events.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("covered %0d reports (%0d short) and %0d key events under four idle mixes",
             reports_taken, short_reports, events_seen);
    if (mismatches == 0) begin
      $display("hid_keyboard_report_diff_unit: match");
    end else begin
      $display("hid_keyboard_report_diff_unit: mismatch");
    end
    $finish;
  end

endmodule
